@@ hdl/rdma_pkg.sv @@
// Package for the routing demand map accumulator.
// Field types, fixed widths and operation codes. No dependencies.
package rdma_pkg;

	localparam int COORD_W = 8;
	localparam int FRAC_W  = 17;
	localparam int UNIT_W  = 4;
	localparam int INDEX_W = 14;
	localparam int VALUE_W = 32;
	localparam int CNT_W   = 11;
	localparam int SIDE_W  = 9;
	localparam int LEN_W   = 9;
	localparam int AREA_W  = 17;
	localparam int PROD_W  = FRAC_W + LEN_W;

	localparam logic [CNT_W-1:0] COUNT_MAX = '1;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [FRAC_W-1:0]         frac_t;
	typedef logic [UNIT_W-1:0]         unit_t;
	typedef logic [INDEX_W-1:0]        index_t;
	typedef logic [VALUE_W-1:0]        value_t;
	typedef logic [CNT_W-1:0]          count_t;

	typedef enum logic {
		OP_ADD  = 1'b0,
		OP_READ = 1'b1
	} op_t;

endpackage

@@ hdl/rudy_demand_map_accumulate.sv @@
// Routing demand map accumulator: per-cell, per-unit Q16.16 demand words in one memory.
// Depends on rdma_pkg.
//
// Input channel (in_valid/in_ready) carries one transaction per operation. An add
// transaction spreads rho = fraction*L/A over the in-grid cells of a box in one unit
// plane; a read transaction returns one map word. Every transaction yields exactly one
// result on the output channel (out_valid/out_ready).
// Add: set-up in S_PREP, S_MUL and S_ADDR, the restoring divider in S_DIV, then each covered
// cell through the map port in S_CELLS, a drain of the write stage, then the output register.
// A skipped add goes from S_MUL straight to S_DONE. Read: S_RDREQ and S_RDDATA, then the
// output register. One transaction is in work at a time; in_ready is high
// only while the sequencer is idle. The cell loop is set by the single read and
// single write port of the map memory.
// After reset the map is swept to zero one word per cycle (all GRID_ROWS*GRID_COLS*UNITS
// words, 16384 by default); in_ready stays low during the sweep.
// The result sits in an output register; the next transaction is accepted while it
// waits. If the receiver stalls, a finished transaction holds in the sequencer until
// the output register is free.
module rudy_demand_map_accumulate #(
	parameter int GRID_ROWS = 32,
	parameter int GRID_COLS = 32,
	parameter int UNITS     = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            operation,
	input  rdma_pkg::coord_t corner_a_row,
	input  rdma_pkg::coord_t corner_a_col,
	input  rdma_pkg::coord_t corner_b_row,
	input  rdma_pkg::coord_t corner_b_col,
	input  rdma_pkg::unit_t  unit,
	input  rdma_pkg::frac_t  fraction,
	input  rdma_pkg::index_t read_index,
	output logic            out_valid,
	input  logic            out_ready,
	output rdma_pkg::value_t read_value,
	output rdma_pkg::count_t cells_updated
);
	import rdma_pkg::*;

	localparam int MAP_WORDS  = GRID_ROWS * GRID_COLS * UNITS;
	localparam int AW         = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int ROW_STRIDE = GRID_COLS * UNITS;
	localparam logic signed [SIDE_W-1:0] ROW_MAX = SIDE_W'(GRID_ROWS - 1);
	localparam logic signed [SIDE_W-1:0] COL_MAX = SIDE_W'(GRID_COLS - 1);
	localparam int DIV_CNT_W  = $clog2(PROD_W);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_PREP,
		S_MUL,
		S_ADDR,
		S_DIV,
		S_CELLS,
		S_RDREQ,
		S_RDDATA,
		S_DONE
	} state_t;

	state_t state_q;

	// captured transaction
	coord_t a_row_q, a_col_q, b_row_q, b_col_q;
	unit_t  unit_q;
	frac_t  frac_q;
	logic [AW-1:0] rd_addr_q;
	logic          in_range_q;

	// set-up
	logic [LEN_W-1:0]     len_q;
	logic [SIDE_W-1:0]    hp1_q, wp1_q;
	logic [COORD_W-1:0]   row_lo_q, row_hi_q, col_lo_q, col_hi_q;
	logic                 skip_q;
	logic [AREA_W-1:0]    area_q;
	logic [PROD_W-1:0]    prod_q;
	logic [AW-1:0]        rc_q;

	// divider
	logic [AREA_W:0]      rem_q;
	logic [PROD_W-1:0]    quo_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;

	// cell loop
	logic [COORD_W-1:0] row_q, col_q;
	logic [AW-1:0]      addr_q, row_addr_q, wr_addr_s1, clr_cnt_q;
	logic               issue_q, pend_s1;
	count_t             cnt_q;

	// results
	value_t res_value_q;
	count_t res_cells_q;
	value_t out_value_q;
	count_t out_cells_q;
	logic   out_valid_q;

	// memory
	value_t mem_q [MAP_WORDS];
	value_t rdata_q;
	logic          mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	value_t        mem_wdata;

	// combinational set-up
	coord_t r_lo, r_hi, c_lo, c_hi;
	logic signed [SIDE_W-1:0] h9, w9, rlo9, rhi9, clo9, chi9;
	logic signed [SIDE_W-1:0] rclo9, rchi9, cclo9, cchi9;
	logic [LEN_W-1:0] len_c;
	logic             empty_c;

	logic [AREA_W:0]  rem_sh;
	logic [AREA_W:0]  rem_diff;
	logic [VALUE_W:0] sum_c;
	logic [AW-1:0]    rd_addr_c;
	logic             accept;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign read_value    = out_value_q;
	assign cells_updated = out_cells_q;
	assign rd_addr_c = AW'(32'(read_index));

	always_comb begin
		r_lo = (a_row_q < b_row_q) ? a_row_q : b_row_q;
		r_hi = (a_row_q < b_row_q) ? b_row_q : a_row_q;
		c_lo = (a_col_q < b_col_q) ? a_col_q : b_col_q;
		c_hi = (a_col_q < b_col_q) ? b_col_q : a_col_q;
		rlo9 = SIDE_W'(r_lo);
		rhi9 = SIDE_W'(r_hi);
		clo9 = SIDE_W'(c_lo);
		chi9 = SIDE_W'(c_hi);
		h9 = rhi9 - rlo9;
		w9 = chi9 - clo9;
		len_c = LEN_W'(h9) + LEN_W'(w9);
		rclo9 = rlo9[SIDE_W-1] ? '0 : rlo9;
		rchi9 = (rhi9 > ROW_MAX) ? ROW_MAX : rhi9;
		cclo9 = clo9[SIDE_W-1] ? '0 : clo9;
		cchi9 = (chi9 > COL_MAX) ? COL_MAX : chi9;
		empty_c = (rclo9 > rchi9) || (cclo9 > cchi9);
	end

	always_comb begin
		rem_sh   = {rem_q[AREA_W-1:0], quo_q[PROD_W-1]};
		rem_diff = rem_sh - {1'b0, area_q};
		sum_c    = {1'b0, rdata_q} + (VALUE_W+1)'(quo_q);
	end

	always_comb begin
		mem_raddr = (state_q == S_RDREQ) ? rd_addr_q : addr_q;
		mem_we    = (state_q == S_CLEAR) || (state_q == S_CELLS && pend_s1);
		mem_waddr = (state_q == S_CLEAR) ? clr_cnt_q : wr_addr_s1;
		if (state_q == S_CLEAR) begin
			mem_wdata = '0;
		end else begin
			mem_wdata = sum_c[VALUE_W] ? '1 : sum_c[VALUE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem_q[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_cnt_q   <= '0;
			issue_q     <= 1'b0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == AW'(MAP_WORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						a_row_q    <= corner_a_row;
						a_col_q    <= corner_a_col;
						b_row_q    <= corner_b_row;
						b_col_q    <= corner_b_col;
						unit_q     <= unit;
						frac_q     <= fraction;
						rd_addr_q  <= rd_addr_c;
						in_range_q <= (32'(read_index) < 32'(MAP_WORDS));
						state_q    <= (op_t'(operation) == OP_READ) ? S_RDREQ : S_PREP;
					end
				end
				S_PREP: begin
					len_q    <= len_c;
					hp1_q    <= SIDE_W'(h9) + 1'b1;
					wp1_q    <= SIDE_W'(w9) + 1'b1;
					row_lo_q <= rclo9[COORD_W-1:0];
					row_hi_q <= rchi9[COORD_W-1:0];
					col_lo_q <= cclo9[COORD_W-1:0];
					col_hi_q <= cchi9[COORD_W-1:0];
					skip_q   <= (len_c == '0) || (frac_q == '0) || empty_c ||
						(32'(unit_q) >= 32'(UNITS));
					state_q  <= S_MUL;
				end
				S_MUL: begin
					area_q <= AREA_W'(hp1_q) * AREA_W'(wp1_q);
					prod_q <= PROD_W'(frac_q) * PROD_W'(len_q);
					rc_q   <= AW'(32'(row_lo_q) * 32'(GRID_COLS) + 32'(col_lo_q));
					if (skip_q) begin
						res_value_q <= '0;
						res_cells_q <= '0;
						state_q     <= S_DONE;
					end else begin
						state_q <= S_ADDR;
					end
				end
				S_ADDR: begin
					addr_q     <= AW'(32'(rc_q) * 32'(UNITS) + 32'(unit_q));
					row_addr_q <= AW'(32'(rc_q) * 32'(UNITS) + 32'(unit_q));
					quo_q      <= prod_q;
					rem_q      <= '0;
					div_cnt_q  <= '0;
					state_q    <= S_DIV;
				end
				S_DIV: begin
					if (!rem_diff[AREA_W]) begin
						rem_q <= rem_diff;
						quo_q <= {quo_q[PROD_W-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						quo_q <= {quo_q[PROD_W-2:0], 1'b0};
					end
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == DIV_CNT_W'(PROD_W - 1)) begin
						row_q   <= row_lo_q;
						col_q   <= col_lo_q;
						cnt_q   <= '0;
						issue_q <= 1'b1;
						state_q <= S_CELLS;
					end
				end
				S_CELLS: begin
					pend_s1    <= issue_q;
					wr_addr_s1 <= addr_q;
					if (issue_q) begin
						if (cnt_q != COUNT_MAX) begin
							cnt_q <= cnt_q + 1'b1;
						end
						if (col_q == col_hi_q) begin
							if (row_q == row_hi_q) begin
								issue_q <= 1'b0;
							end else begin
								row_q      <= row_q + 1'b1;
								col_q      <= col_lo_q;
								row_addr_q <= row_addr_q + AW'(ROW_STRIDE);
								addr_q     <= row_addr_q + AW'(ROW_STRIDE);
							end
						end else begin
							col_q  <= col_q + 1'b1;
							addr_q <= addr_q + AW'(UNITS);
						end
					end
					if (!issue_q && !pend_s1) begin
						res_value_q <= '0;
						res_cells_q <= cnt_q;
						state_q     <= S_DONE;
					end
				end
				S_RDREQ: begin
					state_q <= S_RDDATA;
				end
				S_RDDATA: begin
					res_value_q <= in_range_q ? rdata_q : '0;
					res_cells_q <= '0;
					state_q     <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_value_q <= res_value_q;
						out_cells_q <= res_cells_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ hdl/rdma_checker.sv @@
// Port checker for the routing demand map accumulator, with its bind.
// Depends on rdma_pkg and rudy_demand_map_accumulate.
module rdma_checker #(
	parameter int GRID_ROWS = 32,
	parameter int GRID_COLS = 32
) (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input rdma_pkg::value_t read_value,
	input rdma_pkg::count_t cells_updated
);
	import rdma_pkg::*;

	localparam int CELL_LIMIT = (GRID_ROWS * GRID_COLS < 2047) ? GRID_ROWS * GRID_COLS : 2047;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_value) && $stable(cells_updated))
		else $error("result changed while stalled");

	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (read_value == '0) || (cells_updated == '0))
		else $error("result carries both a read word and a cell count");

	a_cell_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cells_updated <= CNT_W'(CELL_LIMIT))
		else $error("cell count exceeds the grid");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready straight after a transaction");

endmodule

bind rudy_demand_map_accumulate rdma_checker #(
	.GRID_ROWS(GRID_ROWS),
	.GRID_COLS(GRID_COLS)
) u_rdma_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.read_value(read_value),
	.cells_updated(cells_updated)
);

@@ bench/rudy_demand_map_accumulate_tb.sv @@
// Self-checking bench for rudy_demand_map_accumulate: a directed table, then random traffic
// in three idling phases, checked against a mirror of the demand map.
// Depends on rdma_pkg and the accumulator RTL.
module rudy_demand_map_accumulate_tb;
	import rdma_pkg::*;

	localparam int GRID_ROWS        = 32;
	localparam int GRID_COLS        = 32;
	localparam int UNITS            = 16;
	localparam int MAP_WORDS        = GRID_ROWS * GRID_COLS * UNITS;
	localparam int RANDOM_PER_PHASE = 172;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES     = 32;
	localparam longint CYCLE_LIMIT  = 3_000_000;
	localparam int REPORT_LIMIT     = 10;

	typedef struct packed {
		op_t    op;
		coord_t ar;
		coord_t ac;
		coord_t br;
		coord_t bc;
		unit_t  u;
		frac_t  frac;
		index_t idx;
		bit     fixed;
		value_t want_value;
		count_t want_cells;
	} stim_row_t;

	typedef struct packed {
		value_t value;
		count_t cells;
	} result_t;

	// fixed = 1: expected result as typed; otherwise from the map mirror
	localparam stim_row_t DIRECTED_ROWS [23] = '{
		'{OP_READ,    0,    0,   0,   0,  0,      0,     0, 1'b1,     0,    0},
		'{OP_READ,    0,    0,   0,   0,  0,      0, 16383, 1'b1,     0,    0},
		'{OP_ADD,     5,    5,   5,   5,  3,  65536,     0, 1'b1,     0,    0},
		'{OP_ADD,     0,    0,   3,   3,  3,      0,     0, 1'b1,     0,    0},
		'{OP_ADD,     0,    0,   1,   1,  0,  65536,     0, 1'b1,     0,    4},
		'{OP_READ,    0,    0,   0,   0,  0,      0,     0, 1'b1, 32768,    0},
		'{OP_ADD,  -128, -128, 127, 127, 15, 131071,     0, 1'b1,     0, 1024},
		'{OP_READ,    0,    0,   0,   0,  0,      0, 16383, 1'b1,  1019,    0},
		'{OP_ADD,  -128, -128, 127, 127,  7,      1,     0, 1'b1,     0, 1024},
		'{OP_READ,    0,    0,   0,   0,  0,      0,  5287, 1'b1,     0,    0},
		'{OP_ADD,    40,    0,  60,   5,  4,  65536,     0, 1'b1,     0,    0},
		'{OP_ADD,  -128, -128,  -1,  -1,  4,  65536,     0, 1'b1,     0,    0},
		'{OP_ADD,    -2,   30,   1,  40,  1,  65536,     0, 1'b0,     0,    0},
		'{OP_READ,    0,    0,   0,   0,  0,      0,   497, 1'b0,     0,    0},
		'{OP_ADD,    20,    9,   3,   2, 12,  65536,     0, 1'b0,     0,    0},
		'{OP_READ,    0,    0,   0,   0,  0,      0,  1580, 1'b0,     0,    0},
		'{OP_ADD,   127, -128,-128, 127,  5,  87381,     0, 1'b0,     0,    0},
		'{OP_ADD,     7,    0,   7,  31,  2,  40000,     0, 1'b0,     0,    0},
		'{OP_READ,    0,    0,   0,   0,  0,      0,  3842, 1'b0,     0,    0},
		'{OP_READ,    0,    0,   0,   0,  0,      0, 10922, 1'b0,     0,    0},
		'{OP_READ,    0,    0,   0,   0,  0,      0,  5461, 1'b0,     0,    0},
		'{OP_ADD,    30,   30,  31,  31,  8,  65535,     0, 1'b0,     0,    0},
		'{OP_READ,    0,    0,   0,   0,  0,      0, 16376, 1'b0,     0,    0}
	};

	logic   clk          = 1'b0;
	logic   arst_n       = 1'b0;
	logic   in_valid     = 1'b0;
	logic   operation    = OP_ADD;
	coord_t corner_a_row = '0;
	coord_t corner_a_col = '0;
	coord_t corner_b_row = '0;
	coord_t corner_b_col = '0;
	unit_t  unit         = '0;
	frac_t  fraction     = '0;
	index_t read_index   = '0;
	logic   out_ready    = 1'b0;
	logic   in_ready;
	logic   out_valid;
	value_t read_value;
	count_t cells_updated;

	value_t  demand_map [MAP_WORDS] = '{default: '0};
	result_t pending_results [$];
	int      mismatch_count     = 0;
	longint  cycle_count        = 0;
	int      sender_gap_pct     = 10;
	int      receiver_stall_pct = 79;
	bit      long_hold_wanted   = 1'b0;
	bit      long_hold_done     = 1'b0;

	rudy_demand_map_accumulate #(
		.GRID_ROWS(GRID_ROWS),
		.GRID_COLS(GRID_COLS),
		.UNITS(UNITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.corner_a_row(corner_a_row),
		.corner_a_col(corner_a_col),
		.corner_b_row(corner_b_row),
		.corner_b_col(corner_b_col),
		.unit(unit),
		.fraction(fraction),
		.read_index(read_index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.read_value(read_value),
		.cells_updated(cells_updated)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Applies one transaction to the map mirror and returns its result.
	function automatic result_t predict_demand(input stim_row_t row);
		result_t         res;
		coord_t          ar, ac, br, bc;
		int              r_lo, r_hi, c_lo, c_hi, len, word;
		longint unsigned area, rho, sum;
		res = '0;
		ar = row.ar;
		ac = row.ac;
		br = row.br;
		bc = row.bc;
		if (row.op == OP_READ) begin
			if (int'(row.idx) < MAP_WORDS)
				res.value = demand_map[row.idx];
			return res;
		end
		r_lo = (ar < br) ? ar : br;
		r_hi = (ar < br) ? br : ar;
		c_lo = (ac < bc) ? ac : bc;
		c_hi = (ac < bc) ? bc : ac;
		len = (r_hi - r_lo) + (c_hi - c_lo);
		if (len == 0 || int'(row.u) >= UNITS || row.frac == '0)
			return res;
		area = longint'(r_hi - r_lo + 1) * longint'(c_hi - c_lo + 1);
		rho = (longint'(row.frac) * len) / area;
		if (r_lo < 0) r_lo = 0;
		if (c_lo < 0) c_lo = 0;
		if (r_hi > GRID_ROWS - 1) r_hi = GRID_ROWS - 1;
		if (c_hi > GRID_COLS - 1) c_hi = GRID_COLS - 1;
		for (int r = r_lo; r <= r_hi; r++) begin
			for (int c = c_lo; c <= c_hi; c++) begin
				word = (r * GRID_COLS + c) * UNITS + int'(row.u);
				sum = longint'(demand_map[word]) + rho;
				demand_map[word] = (sum > 64'hFFFF_FFFF) ? {VALUE_W{1'b1}} : value_t'(sum);
				if (res.cells < COUNT_MAX)
					res.cells = res.cells + 1'b1;
			end
		end
		return res;
	endfunction

	// Mostly small boxes and reads around one corner of the grid, so reads hit live words.
	function automatic stim_row_t random_request();
		stim_row_t row;
		int        kind, r0, c0;
		row.op = OP_ADD;
		row.ar = coord_t'($urandom());
		row.ac = coord_t'($urandom());
		row.br = coord_t'($urandom());
		row.bc = coord_t'($urandom());
		row.u = unit_t'($urandom());
		row.frac = frac_t'($urandom());
		row.idx = index_t'($urandom());
		row.fixed = 1'b0;
		row.want_value = '0;
		row.want_cells = '0;
		kind = $urandom_range(99);
		if (kind < 45) begin
			row.op = OP_READ;
			if ($urandom_range(3) != 0)
				row.idx = index_t'((($urandom_range(12) * GRID_COLS + $urandom_range(12))
					* UNITS) + $urandom_range(3));
		end else if (kind < 90) begin
			r0 = int'($urandom_range(15)) - 3;
			c0 = int'($urandom_range(15)) - 3;
			row.ar = coord_t'(r0);
			row.ac = coord_t'(c0);
			row.br = coord_t'(r0 + int'($urandom_range(8)) - 4);
			row.bc = coord_t'(c0 + int'($urandom_range(8)) - 4);
			if ($urandom_range(4) != 0)
				row.u = unit_t'($urandom_range(3));
			case ($urandom_range(9))
				0: row.frac = '0;
				1: row.frac = frac_t'($urandom());
				default: row.frac = frac_t'($urandom_range(65536, 1));
			endcase
		end
		return row;
	endfunction

	task automatic offer_transaction(input stim_row_t row);
		result_t want;
		while ($urandom_range(99) < sender_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		operation    <= row.op;
		corner_a_row <= row.ar;
		corner_a_col <= row.ac;
		corner_b_row <= row.br;
		corner_b_col <= row.bc;
		unit         <= row.u;
		fraction     <= row.frac;
		read_index   <= row.idx;
		@(posedge clk);
		while (in_ready !== 1'b1)
			@(posedge clk);
		want = predict_demand(row);
		if (row.fixed)
			want = {row.want_value, row.want_cells};
		pending_results.insert(pending_results.size(), want);
	endtask

	// Receiver; one long hold-off fills the block and stalls its input.
	initial begin
		forever begin
			@(posedge clk);
			if (long_hold_wanted && !long_hold_done) begin
				long_hold_done = 1'b1;
				out_ready <= 1'b0;
				for (int n = 0; n < LONG_HOLD_CYCLES; n++)
					@(posedge clk);
			end
			out_ready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	always @(posedge clk) begin
		result_t want;
		result_t got;
		got = {read_value, cells_updated};
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("unexpected transaction: read_value %h cells_updated %0d",
						got.value, got.cells);
			end else begin
				want = pending_results.pop_front();
				if (got.value !== want.value || got.cells !== want.cells) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("mismatch: read_value %h/%h cells_updated %0d/%0d (exp/act)",
							want.value, got.value, want.cells, got.cells);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		foreach (DIRECTED_ROWS[i])
			offer_transaction(DIRECTED_ROWS[i]);
		for (int phase = 0; phase < 3; phase++) begin
			if (phase == 1) begin
				sender_gap_pct = 79;
				receiver_stall_pct <= 10;
			end else if (phase == 2) begin
				sender_gap_pct = 0;
				receiver_stall_pct <= 0;
				long_hold_wanted <= 1'b1;
			end
			repeat (RANDOM_PER_PHASE)
				offer_transaction(random_request());
		end
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
